// ===== src/vmt_pkg.sv =====
package vmt_pkg;

    // Default coordinate width in bits (signed Q16.16 at the default).
    localparam int CoordWidthDef = 32;

    // Number of point components.
    localparam int NumAxes = 3;

endpackage

// ===== src/vmt_sqrt.sv =====
module vmt_sqrt
    import vmt_pkg::*;
#(
    parameter int COORD_WIDTH = CoordWidthDef
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [2*COORD_WIDTH+1:0] i_sq,
    output logic [COORD_WIDTH:0]     o_root
);

    // Digit-recurrence integer square root, one result bit per stage.
    localparam int SW = 2 * COORD_WIDTH + 2;
    localparam int N  = COORD_WIDTH + 1;

    logic [SW-1:0] r_op  [0:N];
    logic [SW-1:0] r_res [0:N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op[0]  <= i_sq;
            r_res[0] <= '0;
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_stage
        localparam logic [SW-1:0] One = SW'(1) << (2 * (N - k));
        logic [SW-1:0] trial;
        logic [SW-1:0] n_op;
        logic [SW-1:0] n_res;

        always_comb begin
            trial = r_res[k-1] + One;
            if (r_op[k-1] >= trial) begin
                n_op  = r_op[k-1] - trial;
                n_res = (r_res[k-1] >> 1) + One;
            end else begin
                n_op  = r_op[k-1];
                n_res = r_res[k-1] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_op[k]  <= n_op;
                r_res[k] <= n_res;
            end
        end
    end

    assign o_root = r_res[N][COORD_WIDTH:0];

endmodule

// ===== src/vmt_div.sv =====
module vmt_div
    import vmt_pkg::*;
#(
    parameter int COORD_WIDTH = CoordWidthDef
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [2*COORD_WIDTH:0]   i_num,
    input  logic [COORD_WIDTH:0]     i_den,
    output logic [COORD_WIDTH+1:0]   o_quo
);

    // Restoring division, one quotient bit per stage, rounded to nearest.
    // Quotients of 2^QB or more are reported as 2^QB, which already
    // saturates any coordinate it is added to.
    localparam int NW = 2 * COORD_WIDTH + 1;
    localparam int QB = COORD_WIDTH + 1;
    localparam int DW = COORD_WIDTH + 1;
    localparam int RW = COORD_WIDTH + 2;

    logic [DW-1:0] den0;
    logic          ovf0;

    logic [RW-1:0] r_rem [0:QB];
    logic [QB-1:0] r_low [0:QB];
    logic [QB-1:0] r_quo [0:QB];
    logic [DW-1:0] r_den [0:QB];
    logic          r_ovf [0:QB];
    logic [QB:0]   r_out;

    always_comb begin
        den0 = (i_den == '0) ? DW'(1) : i_den;
        ovf0 = {1'b0, i_num} >= {den0, QB'(0)};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_num[NW-1:QB]);
            r_low[0] <= i_num[QB-1:0];
            r_quo[0] <= '0;
            r_den[0] <= den0;
            r_ovf[0] <= ovf0;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        logic [RW-1:0] trial;
        logic [RW-1:0] n_rem;
        logic          qbit;

        always_comb begin
            trial = {r_rem[k-1][RW-2:0], r_low[k-1][QB-1]};
            qbit  = trial >= RW'(r_den[k-1]);
            n_rem = qbit ? trial - RW'(r_den[k-1]) : trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_low[k] <= {r_low[k-1][QB-2:0], 1'b0};
                r_quo[k] <= {r_quo[k-1][QB-2:0], qbit};
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    logic          rnd;
    logic [QB:0]   n_out;

    always_comb begin
        rnd = {r_rem[QB], 1'b0} >= (RW + 1)'(r_den[QB]);
        if (r_ovf[QB]) begin
            n_out = (QB + 1)'(1) << QB;
        end else begin
            n_out = (QB + 1)'(r_quo[QB]) + (QB + 1)'(rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_quo = r_out;

endmodule

// ===== src/vector3_move_towards_unit.sv =====
// Moves a 3D point toward a target by at most max_step, all coordinates in
// signed fixed point (Q16.16 at the default width). When the squared distance
// is zero, or the step is non-negative and its square reaches the squared
// distance, the target is returned and reached is set; otherwise each
// component moves by round(|d| * |step| / floor(sqrt(|d|^2))), with a negative
// step moving away from the target, and the result saturates. The block is a
// single pipeline that takes one transfer per cycle; its stages are three front
// stages, a COORD_WIDTH + 2 stage square root, a COORD_WIDTH + 3 stage divider
// per axis and the output register. The whole pipeline advances whenever the
// output register is empty or being taken, so a stall on the output holds every
// item in place.
module vector3_move_towards_unit
    import vmt_pkg::*;
#(
    parameter int COORD_WIDTH = CoordWidthDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Input tdata fields from bit 0: cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z,
    // max_step, each COORD_WIDTH bits, zero padded to whole bytes.
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((7*COORD_WIDTH+7)/8)*8-1:0]    i_s_axis_tdata,
    // Output tdata fields from bit 0: new_x, new_y, new_z, zero padded.
    // Output tuser: reached.
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]    o_m_axis_tdata,
    output logic                                  o_m_axis_tuser
);

    localparam int W     = COORD_WIDTH;
    localparam int OTW   = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int SQL   = COORD_WIDTH + 2;
    localparam int DVL   = COORD_WIDTH + 3;
    localparam int TOT   = SQL + DVL;
    localparam int VW    = COORD_WIDTH + 3;

    logic en;

    // Front stage 1: differences and magnitudes.
    logic              r1_v;
    logic [W-1:0]      r1_cur  [0:NumAxes-1];
    logic [W-1:0]      r1_tgt  [0:NumAxes-1];
    logic [W:0]        r1_md   [0:NumAxes-1];
    logic              r1_dn   [0:NumAxes-1];
    logic [W-1:0]      r1_ms;
    logic              r1_sn;

    // Front stage 2: products.
    logic              r2_v;
    logic [W-1:0]      r2_cur  [0:NumAxes-1];
    logic [W-1:0]      r2_tgt  [0:NumAxes-1];
    logic [2*W+1:0]    r2_sq   [0:NumAxes-1];
    logic [2*W:0]      r2_n    [0:NumAxes-1];
    logic              r2_neg  [0:NumAxes-1];
    logic [2*W-1:0]    r2_ssq;
    logic              r2_sn;

    // Front stage 3: squared length and the reached decision.
    logic              r3_v;
    logic [W-1:0]      r3_cur  [0:NumAxes-1];
    logic [W-1:0]      r3_tgt  [0:NumAxes-1];
    logic [2*W:0]      r3_n    [0:NumAxes-1];
    logic              r3_neg  [0:NumAxes-1];
    logic [2*W+1:0]    r3_sq;
    logic              r3_reached;

    // Delay lines that run beside the root and the dividers.
    logic [2*W:0]      r_nd    [0:SQL-1][0:NumAxes-1];
    logic [W-1:0]      r_cd    [0:TOT-1][0:NumAxes-1];
    logic [W-1:0]      r_td    [0:TOT-1][0:NumAxes-1];
    logic              r_gd    [0:TOT-1][0:NumAxes-1];
    logic              r_rd    [0:TOT-1];
    logic              r_vd    [0:TOT-1];

    logic [W:0]        root;
    logic [W+1:0]      quo     [0:NumAxes-1];

    logic              r_ov;
    logic [3*W-1:0]    r_odata;
    logic              r_oreach;
    logic [3*W-1:0]    n_odata;

    assign en              = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // Stage 1.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NumAxes; k++) begin
                logic [W:0] d;
                d = {i_s_axis_tdata[(3+k)*W+W-1], i_s_axis_tdata[(3+k)*W +: W]}
                  - {i_s_axis_tdata[k*W+W-1], i_s_axis_tdata[k*W +: W]};
                r1_cur[k] <= i_s_axis_tdata[k*W +: W];
                r1_tgt[k] <= i_s_axis_tdata[(3+k)*W +: W];
                r1_dn[k]  <= d[W];
                r1_md[k]  <= d[W] ? (W + 1)'(0) - d : d;
            end
            begin
                logic [W:0] s;
                s = {i_s_axis_tdata[6*W+W-1], i_s_axis_tdata[6*W +: W]};
                r1_sn <= s[W];
                r1_ms <= s[W] ? W'((W + 1)'(0) - s) : s[W-1:0];
            end
        end
    end

    // Stage 2.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NumAxes; k++) begin
                r2_cur[k] <= r1_cur[k];
                r2_tgt[k] <= r1_tgt[k];
                r2_sq[k]  <= (2 * W + 2)'(r1_md[k]) * (2 * W + 2)'(r1_md[k]);
                r2_n[k]   <= (2 * W + 1)'(r1_md[k]) * (2 * W + 1)'(r1_ms);
                r2_neg[k] <= r1_dn[k] ^ r1_sn;
            end
            r2_ssq <= (2 * W)'(r1_ms) * (2 * W)'(r1_ms);
            r2_sn  <= r1_sn;
        end
    end

    // Stage 3.
    always_ff @(posedge i_clk) begin
        if (en) begin
            logic [2*W+1:0] s;
            s = r2_sq[0] + r2_sq[1] + r2_sq[2];
            for (int k = 0; k < NumAxes; k++) begin
                r3_cur[k] <= r2_cur[k];
                r3_tgt[k] <= r2_tgt[k];
                r3_n[k]   <= r2_n[k];
                r3_neg[k] <= r2_neg[k];
            end
            r3_sq      <= s;
            r3_reached <= (s == '0) || (!r2_sn && (s <= (2 * W + 2)'(r2_ssq)));
        end
    end

    // Valid bits travel with the data and are the only state reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            for (int i = 0; i < TOT; i++) begin
                r_vd[i] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v    <= i_s_axis_tvalid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r_vd[0] <= r3_v;
            for (int i = 1; i < TOT; i++) begin
                r_vd[i] <= r_vd[i-1];
            end
            r_ov <= r_vd[TOT-1];
        end
    end

    // Payload delay lines.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NumAxes; k++) begin
                r_nd[0][k] <= r3_n[k];
                r_cd[0][k] <= r3_cur[k];
                r_td[0][k] <= r3_tgt[k];
                r_gd[0][k] <= r3_neg[k];
                for (int i = 1; i < SQL; i++) begin
                    r_nd[i][k] <= r_nd[i-1][k];
                end
                for (int i = 1; i < TOT; i++) begin
                    r_cd[i][k] <= r_cd[i-1][k];
                    r_td[i][k] <= r_td[i-1][k];
                    r_gd[i][k] <= r_gd[i-1][k];
                end
            end
            r_rd[0] <= r3_reached;
            for (int i = 1; i < TOT; i++) begin
                r_rd[i] <= r_rd[i-1];
            end
        end
    end

    vmt_sqrt #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sq   (r3_sq),
        .o_root (root)
    );

    for (genvar k = 0; k < NumAxes; k++) begin : g_axis
        vmt_div #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_nd[SQL-1][k]),
            .i_den (root),
            .o_quo (quo[k])
        );
    end

    // Final stage: apply the signed move and saturate, or pass the target.
    always_comb begin
        for (int k = 0; k < NumAxes; k++) begin
            logic [VW-1:0] c;
            logic [VW-1:0] v;
            logic [VW-1:0] hi;
            logic [VW-1:0] lo;
            logic [W-1:0]  s;
            c  = VW'($signed(r_cd[TOT-1][k]));
            hi = VW'({1'b0, {(W - 1){1'b1}}});
            lo = VW'($signed({1'b1, {(W - 1){1'b0}}}));
            v  = r_gd[TOT-1][k] ? c - VW'(quo[k]) : c + VW'(quo[k]);
            if ($signed(v) > $signed(hi)) begin
                s = hi[W-1:0];
            end else if ($signed(v) < $signed(lo)) begin
                s = lo[W-1:0];
            end else begin
                s = v[W-1:0];
            end
            n_odata[k*W +: W] = r_rd[TOT-1] ? r_td[TOT-1][k] : s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_odata  <= n_odata;
            r_oreach <= r_rd[TOT-1];
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = OTW'(r_odata);
    assign o_m_axis_tuser  = r_oreach;

endmodule
